>>> src/glyph_text_framebuffer_blitter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer blitter
// Immediate-implication and next-cycle checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_FRAMEBUFFER_BLITTER_TOP_MACROS_SVH
`define GLYPH_TEXT_FRAMEBUFFER_BLITTER_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define GTFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define GTFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/gtfb_pkg.sv
// ----------------------------------------------------------------------------
// gtfb_pkg
// Shared types, constants and the 5x7 font table of the framebuffer blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtfb_pkg;

   localparam int FRAME_WIDTH_DEF  = 320;
   localparam int FRAME_HEIGHT_DEF = 240;
   localparam int STORE_BYTES_DEF  = (FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF + 1) / 2;

   localparam int COORD_W    = 11;
   localparam int COLOR_W    = 4;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_COLS = 5;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_CHAR  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_FILL,
      ST_DOT,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_PEEK,
      ST_PEEK_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      mode_type            mode;
      logic [9:0]          pos_x;
      logic [9:0]          pos_y;
      logic [9:0]          rect_width;
      logic [9:0]          rect_height;
      logic [7:0]          character_code;
      logic [3:0]          scale;
      logic [COLOR_W-1:0]  color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  pixel_color;
      logic [10:0]         next_x;
      logic                past_right_edge;
   } rsp_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } ram_ctl_type;

   typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_type;

   function automatic glyph_type glyph_lookup(input logic [7:0] code);
      logic [7:0] c;
      glyph_type  g;
      c = ((code >= 8'h61) && (code <= 8'h7A)) ? (code - 8'h20) : code;
      unique case (c)
         8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
         8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
         8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
         8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
         8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         8'h4E: g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
         8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         8'h23: g = {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00};
         8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
         8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
         8'h3A: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
         8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
         default: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
      endcase
      return g;
   endfunction

endpackage

>>> src/glyph_text_framebuffer_blitter_top.sv
// ----------------------------------------------------------------------------
// glyph_text_framebuffer_blitter_top
// Clear, rectangle fill, scaled 5x7 character drawing and pixel read on a
// 4-bit-per-pixel frame packed two pixels per byte.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. All pixel traffic goes
// through a single-port byte memory, so every written pixel costs a read and
// a write of its byte. Clear sweeps all (FRAME_WIDTH*FRAME_HEIGHT+1)/2 bytes
// of the store, 38400 at 320x240, one byte per cycle, and the same sweep runs
// once after reset with req_stall high (csr writes are taken throughout).
// Fill clips the box, then reads and writes each clipped pixel. A character
// walks the 35 glyph dots and draws each lit one as a clipped box; scale 0
// draws nothing. A read returns the stored pixel, or the background color off
// frame. The next request is accepted while a response waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_text_framebuffer_blitter_top #(
   parameter int FRAME_WIDTH  = gtfb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = gtfb_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gtfb_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gtfb_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [gtfb_pkg::COLOR_W-1:0]   csr_wr_data
);
   import gtfb_pkg::*;

   `include "glyph_text_framebuffer_blitter_top_macros.svh"

   localparam int STORE_BYTES = (FRAME_WIDTH * FRAME_HEIGHT + 1) / 2;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int PIXW        = AW + 1;

   localparam logic [COORD_W-1:0] LIM_X     = COORD_W'(FRAME_WIDTH);
   localparam logic [COORD_W-1:0] LIM_Y     = COORD_W'(FRAME_HEIGHT);
   localparam logic [AW-1:0]      LAST_BYTE = AW'(STORE_BYTES - 1);
   localparam logic [2:0]         ROW_LAST  = 3'(GLYPH_ROWS - 1);
   localparam logic [2:0]         COL_LAST  = 3'(GLYPH_COLS - 1);

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [9:0]           pos_x_ff, pos_x_in;
   logic [9:0]           rw_ff, rw_in;
   logic [9:0]           rh_ff, rh_in;
   logic [3:0]           scale_ff, scale_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   glyph_type            glyph_ff, glyph_in;
   logic [2:0]           dot_row_ff, dot_row_in;
   logic [2:0]           dot_col_ff, dot_col_in;
   logic [COORD_W-1:0]   dot_x_ff, dot_x_in;
   logic [COORD_W-1:0]   dot_y_ff, dot_y_in;
   logic [COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]   org_x_ff, org_x_in;
   logic [COORD_W-1:0]   end_x_ff, end_x_in;
   logic [COORD_W-1:0]   end_y_ff, end_y_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 odd_ff, odd_in;
   logic [COLOR_W-1:0]   pix_ff, pix_in;
   logic [AW-1:0]        wipe_ff, wipe_in;
   logic                 reply_ff, reply_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [COLOR_W-1:0]   bg_ff, bg_in;

   logic                 req_fire;
   logic                 rsp_load;
   ram_ctl_type          ram_ctl;
   logic [AW-1:0]        ram_addr;
   logic [7:0]           ram_wr_data;
   logic [7:0]           ram_rd_data;

   logic [COORD_W-1:0]   box_org_x, box_org_y, box_size_x, box_size_y;
   logic [COORD_W:0]     box_sum_x, box_sum_y;
   logic [COORD_W-1:0]   box_end_x, box_end_y;
   logic                 box_empty;
   logic                 glyph_bit;
   logic                 dot_last;
   logic [2:0]           dot_row_nx, dot_col_nx;
   logic [COORD_W-1:0]   dot_x_nx, dot_y_nx;
   logic [PIXW-1:0]      pix_index;
   logic [COORD_W-1:0]   cur_x_inc, cur_y_inc;
   logic                 x_more, y_more;
   logic                 in_frame;
   logic [COORD_W-1:0]   pen_x;

   assign req_fire = req_valid && !req_stall;

   // ---- box clipping, shared by fill and glyph dots
   always_comb begin
      if (state_ff == ST_DOT) begin
         box_org_x  = dot_x_ff;
         box_org_y  = dot_y_ff;
         box_size_x = COORD_W'(scale_ff);
         box_size_y = COORD_W'(scale_ff);
      end else begin
         box_org_x  = cur_x_ff;
         box_org_y  = cur_y_ff;
         box_size_x = COORD_W'(rw_ff);
         box_size_y = COORD_W'(rh_ff);
      end
      box_sum_x = {1'b0, box_org_x} + {1'b0, box_size_x};
      box_sum_y = {1'b0, box_org_y} + {1'b0, box_size_y};
      box_end_x = (box_sum_x > {1'b0, LIM_X}) ? LIM_X : box_sum_x[COORD_W-1:0];
      box_end_y = (box_sum_y > {1'b0, LIM_Y}) ? LIM_Y : box_sum_y[COORD_W-1:0];
      box_empty = (box_org_x >= box_end_x) || (box_org_y >= box_end_y);
   end

   // ---- glyph dot walk
   always_comb begin
      glyph_bit = glyph_ff[dot_row_ff][COL_LAST - dot_col_ff];
      dot_last  = (dot_row_ff == ROW_LAST) && (dot_col_ff == COL_LAST);
      if (dot_col_ff == COL_LAST) begin
         dot_col_nx = 3'd0;
         dot_row_nx = dot_row_ff + 3'd1;
         dot_x_nx   = COORD_W'(pos_x_ff);
         dot_y_nx   = dot_y_ff + COORD_W'(scale_ff);
      end else begin
         dot_col_nx = dot_col_ff + 3'd1;
         dot_row_nx = dot_row_ff;
         dot_x_nx   = dot_x_ff + COORD_W'(scale_ff);
         dot_y_nx   = dot_y_ff;
      end
   end

   // ---- pixel walk and addressing
   always_comb begin
      pix_index = PIXW'(cur_y_ff) * PIXW'(FRAME_WIDTH) + PIXW'(cur_x_ff);
      cur_x_inc = cur_x_ff + COORD_W'(1);
      cur_y_inc = cur_y_ff + COORD_W'(1);
      x_more    = cur_x_inc < end_x_ff;
      y_more    = cur_y_inc < end_y_ff;
      in_frame  = (cur_x_ff < LIM_X) && (cur_y_ff < LIM_Y);
      pen_x     = COORD_W'(pos_x_ff) + COORD_W'({scale_ff, 2'b00})
                + COORD_W'({scale_ff, 1'b0});
   end

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            if (wipe_ff == LAST_BYTE) begin
               state_in = reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.mode)
                  MODE_CLEAR: state_in = ST_WIPE;
                  MODE_FILL:  state_in = ST_FILL;
                  MODE_CHAR:  state_in = (req_data.scale == 4'd0) ? ST_DONE : ST_DOT;
                  MODE_READ:  state_in = ST_PEEK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: state_in = box_empty ? ST_DONE : ST_PIX_RD;
         ST_DOT: begin
            priority if (glyph_bit && !box_empty) begin
               state_in = ST_PIX_RD;
            end else if (dot_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DOT;
            end
         end
         ST_PIX_RD: state_in = ST_PIX_WR;
         ST_PIX_WR: begin
            priority if (x_more || y_more) begin
               state_in = ST_PIX_RD;
            end else if (mode_ff == MODE_FILL || dot_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DOT;
            end
         end
         ST_PEEK:      state_in = in_frame ? ST_PEEK_WAIT : ST_DONE;
         ST_PEEK_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the state machine
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      ram_ctl.rd  = (state_ff == ST_PIX_RD) || ((state_ff == ST_PEEK) && in_frame);
      ram_ctl.wr  = (state_ff == ST_WIPE) || (state_ff == ST_PIX_WR);
      ram_wr_data = odd_ff ? {ram_rd_data[7:4], color_ff} : {color_ff, ram_rd_data[3:0]};
      unique case (state_ff)
         ST_WIPE: begin
            ram_addr    = wipe_ff;
            ram_wr_data = 8'h00;
         end
         ST_PIX_WR: ram_addr = addr_ff;
         default:   ram_addr = pix_index[AW:1];
      endcase
   end

   // ---- datapath
   always_comb begin
      mode_in      = mode_ff;
      pos_x_in     = pos_x_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      scale_in     = scale_ff;
      color_in     = color_ff;
      glyph_in     = glyph_ff;
      dot_row_in   = dot_row_ff;
      dot_col_in   = dot_col_ff;
      dot_x_in     = dot_x_ff;
      dot_y_in     = dot_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      org_x_in     = org_x_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      addr_in      = addr_ff;
      odd_in       = odd_ff;
      pix_in       = pix_ff;
      wipe_in      = wipe_ff;
      reply_in     = reply_ff;
      rsp_data_in  = rsp_data_ff;
      bg_in        = csr_wr_en ? csr_wr_data : bg_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         ST_WIPE: begin
            if (wipe_ff == LAST_BYTE) begin
               wipe_in  = '0;
               reply_in = 1'b0;
            end else begin
               wipe_in = wipe_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in    = req_data.mode;
               pos_x_in   = req_data.pos_x;
               rw_in      = req_data.rect_width;
               rh_in      = req_data.rect_height;
               scale_in   = req_data.scale;
               color_in   = req_data.color;
               glyph_in   = glyph_lookup(req_data.character_code);
               dot_row_in = 3'd0;
               dot_col_in = 3'd0;
               dot_x_in   = COORD_W'(req_data.pos_x);
               dot_y_in   = COORD_W'(req_data.pos_y);
               cur_x_in   = COORD_W'(req_data.pos_x);
               cur_y_in   = COORD_W'(req_data.pos_y);
               org_x_in   = COORD_W'(req_data.pos_x);
               pix_in     = '0;
               reply_in   = (req_data.mode == MODE_CLEAR);
            end
         end
         ST_FILL: begin
            end_x_in = box_end_x;
            end_y_in = box_end_y;
         end
         ST_DOT: begin
            priority if (glyph_bit && !box_empty) begin
               cur_x_in = dot_x_ff;
               cur_y_in = dot_y_ff;
               org_x_in = dot_x_ff;
               end_x_in = box_end_x;
               end_y_in = box_end_y;
            end else if (!dot_last) begin
               dot_row_in = dot_row_nx;
               dot_col_in = dot_col_nx;
               dot_x_in   = dot_x_nx;
               dot_y_in   = dot_y_nx;
            end else begin
               dot_row_in = dot_row_ff;
            end
         end
         ST_PIX_RD: begin
            addr_in = pix_index[AW:1];
            odd_in  = pix_index[0];
         end
         ST_PIX_WR: begin
            priority if (x_more) begin
               cur_x_in = cur_x_inc;
            end else if (y_more) begin
               cur_x_in = org_x_ff;
               cur_y_in = cur_y_inc;
            end else if (mode_ff == MODE_CHAR && !dot_last) begin
               dot_row_in = dot_row_nx;
               dot_col_in = dot_col_nx;
               dot_x_in   = dot_x_nx;
               dot_y_in   = dot_y_nx;
            end else begin
               cur_x_in = cur_x_ff;
            end
         end
         ST_PEEK: begin
            odd_in = pix_index[0];
            if (!in_frame) begin
               pix_in = bg_ff;
            end
         end
         ST_PEEK_WAIT: begin
            pix_in = odd_ff ? ram_rd_data[3:0] : ram_rd_data[7:4];
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in.pixel_color     = (mode_ff == MODE_READ) ? pix_ff : '0;
               rsp_data_in.next_x          = (mode_ff == MODE_CHAR) ? pen_x
                                                                    : COORD_W'(pos_x_ff);
               rsp_data_in.past_right_edge = (mode_ff == MODE_CHAR) && (pen_x >= LIM_X);
            end
         end
         default: begin
            pix_in = pix_ff;
         end
      endcase
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bg_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         bg_ff        <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      pos_x_ff    <= pos_x_in;
      rw_ff       <= rw_in;
      rh_ff       <= rh_in;
      scale_ff    <= scale_in;
      color_ff    <= color_in;
      glyph_ff    <= glyph_in;
      dot_row_ff  <= dot_row_in;
      dot_col_ff  <= dot_col_in;
      dot_x_ff    <= dot_x_in;
      dot_y_ff    <= dot_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      org_x_ff    <= org_x_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      addr_ff     <= addr_in;
      odd_ff      <= odd_in;
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   gtfb_frame_ram #(
      .DEPTH (STORE_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks
   `GTFB_ASSERT_SAME(a_pix_rd_clipped, clock, reset, state_ff == ST_PIX_RD, (end_x_ff <= LIM_X) && (end_y_ff <= LIM_Y) && (cur_x_ff < end_x_ff) && (cur_y_ff < end_y_ff), "pixel read outside clipped box")
   `GTFB_ASSERT_SAME(a_pix_wr_in_frame, clock, reset, state_ff == ST_PIX_WR, in_frame, "pixel write outside frame")
   `GTFB_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "response dropped while slot busy")

endmodule

>>> src/gtfb_frame_ram.sv
// ----------------------------------------------------------------------------
// gtfb_frame_ram
// Single-port frame store, one byte per entry, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtfb_frame_ram #(
   parameter int  DEPTH  = gtfb_pkg::STORE_BYTES_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  gtfb_pkg::ram_ctl_type  ram_ctl,
   input  logic [ADDR_W-1:0]      addr,
   input  logic [7:0]             wr_data,
   output logic [7:0]             rd_data
);
   import gtfb_pkg::*;

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.wr) begin
         store_mem[addr] <= wr_data;
      end
      if (ram_ctl.rd) begin
         rd_data_ff <= store_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
